/* src/dkba_pkg.sv */
`default_nettype none
package dkba_pkg;

  // The table depth must be a power of two: the home slot is the low bits of the hash
  // and the probe pointer wraps by overflow.
  localparam int TABLE_DEPTH = 256;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int ADDR_W      = 64;
  localparam int HANDLE_W    = 64;
  localparam int FMT_W       = 8;
  localparam int BATCH_W     = 8;
  localparam int COUNT_W     = BATCH_W + 1;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int HASH_W      = 64;
  localparam int PARTS       = 6;
  localparam int STEP_W      = $clog2(PARTS);

  localparam logic [HASH_W-1:0] GOLDEN_MIX = 64'h9e37_79b9_7f4a_7c15;
  localparam int MIX_SHL = 6;
  localparam int MIX_SHR = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_PIPELINE_HANDLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_SIG_HANDLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FORMAT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_FORMAT    = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0]  vaddr;
    logic [ADDR_W-1:0]  iaddr;
    logic [BATCH_W-1:0] batch;
  } slot_entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    slot_entry_t       wr_entry;
    logic              clr;
  } table_req_t;

  function automatic logic [HASH_W-1:0] mix_part(input logic [HASH_W-1:0] h,
                                                 input logic [HASH_W-1:0] v);
    return h ^ (v + GOLDEN_MIX + (h << MIX_SHL) + (h >> MIX_SHR));
  endfunction

endpackage
`default_nettype wire

/* src/dkba_hash.sv */
`default_nettype none
module dkba_hash (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            go,
  input  wire [dkba_pkg::HANDLE_W-1:0]   pipeline_handle,
  input  wire [dkba_pkg::HANDLE_W-1:0]   root_signature_handle,
  input  wire [dkba_pkg::ADDR_W-1:0]     vaddr,
  input  wire [dkba_pkg::ADDR_W-1:0]     iaddr,
  input  wire [dkba_pkg::FMT_W-1:0]      target_format,
  input  wire [dkba_pkg::FMT_W-1:0]      depth_format,
  output logic                           done,
  output logic [dkba_pkg::HASH_W-1:0]    hash
);
  import dkba_pkg::*;

  logic              run_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [HASH_W-1:0] h_r;
  logic [HASH_W-1:0] part;

  // One key part is folded in per cycle, in the fixed order of the key.
  always_comb begin
    case (step_r)
      3'd0:    part = pipeline_handle;
      3'd1:    part = root_signature_handle;
      3'd2:    part = vaddr;
      3'd3:    part = iaddr;
      3'd4:    part = {{(HASH_W-FMT_W){1'b0}}, target_format};
      default: part = {{(HASH_W-FMT_W){1'b0}}, depth_format};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(PARTS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      h_r <= '0;
    end else if (run_r) begin
      h_r <= mix_part(h_r, part);
    end
  end

  assign done = done_r;
  assign hash = h_r;

  a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !run_r) else $error("hash done while still running");
  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r && !go && step_r == STEP_W'(PARTS - 1)) |=> done_r)
    else $error("hash run did not finish after the last part");

endmodule
`default_nettype wire

/* src/dkba_table.sv */
`default_nettype none
module dkba_table (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire dkba_pkg::table_req_t req,
  output logic                      rd_valid,
  output dkba_pkg::slot_entry_t     rd_entry
);
  import dkba_pkg::*;

  slot_entry_t            mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_r;
  logic                   rd_valid_r;
  slot_entry_t            rd_entry_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_entry;
    end
    if (req.rd_en) begin
      rd_entry_r <= mem[req.rd_addr];
    end
  end

  // Valid bits live in flops so that a list start empties the table at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req.clr) begin
        valid_r <= '0;
      end else if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid_r <= valid_r[req.rd_addr] & ~req.clr;
      end
    end
  end

  assign rd_valid = rd_valid_r;
  assign rd_entry = rd_entry_r;

  a_no_wr_on_clr: assert property (@(posedge clk) disable iff (!rst_n)
    req.wr_en |-> !req.clr) else $error("table write during clear");
  a_wr_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (req.wr_en && !req.clr) |=> valid_r[$past(req.wr_addr)])
    else $error("written slot not marked valid");

endmodule
`default_nettype wire

/* src/draw_key_batch_assigner_unit.sv */
// Flow: an accepted item is hashed, its home slot is read, and one extra probe follows for
// each occupied slot that does not match, until the probe ends with a hit, an insert or full.
// Throughput: one item at a time; the next start is taken in the cycle the result strobes.
// The six-step hash unit and the one-probe-per-cycle table read set how long an item takes.
// Results cannot be stalled by the receiver.
// Reset (synchronous, rst_n low): table empty, batch count zero, configuration and output registers zero, idle.
`default_nettype none
module draw_key_batch_assigner_unit (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  wire [dkba_pkg::ADDR_W-1:0]       in_vertex_buffer_addr,
  input  wire [dkba_pkg::ADDR_W-1:0]       in_index_buffer_addr,
  input  wire                              in_list_start,
  output logic                             out_strobe,
  output logic [dkba_pkg::BATCH_W-1:0]     out_batch_index,
  output logic                             out_new_batch,
  output logic                             out_table_full,
  input  wire                              cfg_we,
  input  wire [dkba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [dkba_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import dkba_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_HASH, S_PROBE} state_t;

  state_t              state_r;
  logic [HANDLE_W-1:0] pipe_handle_r;
  logic [HANDLE_W-1:0] root_handle_r;
  logic [FMT_W-1:0]    target_fmt_r;
  logic [FMT_W-1:0]    depth_fmt_r;
  logic [ADDR_W-1:0]   vaddr_r;
  logic [ADDR_W-1:0]   iaddr_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [SLOT_W-1:0]   probes_r;
  logic [COUNT_W-1:0]  batch_count_r;
  logic                strobe_r;
  logic [BATCH_W-1:0]  batch_index_r;
  logic                new_batch_r;
  logic                table_full_r;

  logic                accept;
  logic                hash_done;
  logic [HASH_W-1:0]   hash;
  table_req_t          tbl_req;
  logic                rd_valid;
  slot_entry_t         rd_entry;
  logic                hit;
  logic                insert;
  logic                full;
  logic                advance;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_handle_r <= '0;
      root_handle_r <= '0;
      target_fmt_r  <= '0;
      depth_fmt_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PIPELINE_HANDLE: pipe_handle_r <= cfg_wdata;
        CFG_ROOT_SIG_HANDLE: root_handle_r <= cfg_wdata;
        CFG_TARGET_FORMAT:   target_fmt_r  <= cfg_wdata[FMT_W-1:0];
        CFG_DEPTH_FORMAT:    depth_fmt_r   <= cfg_wdata[FMT_W-1:0];
        default:             ;
      endcase
    end
  end

  dkba_hash u_hash (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .go                    (accept),
    .pipeline_handle       (pipe_handle_r),
    .root_signature_handle (root_handle_r),
    .vaddr                 (vaddr_r),
    .iaddr                 (iaddr_r),
    .target_format         (target_fmt_r),
    .depth_format          (depth_fmt_r),
    .done                  (hash_done),
    .hash                  (hash)
  );

  // In the probe state the table output belongs to slot_r, read in the previous cycle.
  assign hit     = rd_valid && (rd_entry.vaddr == vaddr_r) && (rd_entry.iaddr == iaddr_r);
  assign insert  = (state_r == S_PROBE) && !rd_valid && !batch_count_r[COUNT_W-1];
  assign full    = (state_r == S_PROBE) &&
                   ((!rd_valid && batch_count_r[COUNT_W-1]) ||
                    (rd_valid && !hit && (probes_r == {SLOT_W{1'b1}})));
  assign advance = (state_r == S_PROBE) && rd_valid && !hit && (probes_r != {SLOT_W{1'b1}});

  always_comb begin
    tbl_req                = '0;
    tbl_req.clr            = accept && in_list_start;
    tbl_req.wr_en          = insert;
    tbl_req.wr_addr        = slot_r;
    tbl_req.wr_entry.vaddr = vaddr_r;
    tbl_req.wr_entry.iaddr = iaddr_r;
    tbl_req.wr_entry.batch = batch_count_r[BATCH_W-1:0];
    if ((state_r == S_HASH) && hash_done) begin
      tbl_req.rd_en   = 1'b1;
      tbl_req.rd_addr = hash[SLOT_W-1:0];
    end else if (advance) begin
      tbl_req.rd_en   = 1'b1;
      tbl_req.rd_addr = slot_r + 1'b1;
    end
  end

  dkba_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (tbl_req),
    .rd_valid (rd_valid),
    .rd_entry (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      batch_count_r <= '0;
      strobe_r      <= 1'b0;
      batch_index_r <= '0;
      new_batch_r   <= 1'b0;
      table_full_r  <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            vaddr_r <= in_vertex_buffer_addr;
            iaddr_r <= in_index_buffer_addr;
            if (in_list_start) begin
              batch_count_r <= '0;
            end
            state_r <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            slot_r   <= hash[SLOT_W-1:0];
            probes_r <= '0;
            state_r  <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (advance) begin
            slot_r   <= slot_r + 1'b1;
            probes_r <= probes_r + 1'b1;
          end else begin
            strobe_r     <= 1'b1;
            new_batch_r  <= insert;
            table_full_r <= full;
            if (insert) begin
              batch_index_r <= batch_count_r[BATCH_W-1:0];
              batch_count_r <= batch_count_r + 1'b1;
            end else if (hit) begin
              batch_index_r <= rd_entry.batch;
            end else begin
              batch_index_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_strobe      = strobe_r;
  assign out_batch_index = batch_index_r;
  assign out_new_batch   = new_batch_r;
  assign out_table_full  = table_full_r;

  a_full_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_new_batch && out_table_full))
    else $error("result both new and full");
  a_full_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_table_full) |-> (out_batch_index == '0))
    else $error("full result with non-zero batch index");
  a_new_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_new_batch) |->
      (batch_count_r == ({1'b0, out_batch_index} + COUNT_W'(1))))
    else $error("new batch does not match batch count");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("not busy after accepting a beat");

endmodule
`default_nettype wire
